// File: rtl/aass_pkg.sv
// ---------------------------------------------------------------------------
// aass_pkg
// Shared widths, register indexes, command/status types and the signed
// saturation helper for the ADC average/scale/smooth block.
// ---------------------------------------------------------------------------
package aass_pkg;

   localparam int unsigned MAX_BURST_DEFAULT = 64;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned LEN_CFG_W   = 7;
   localparam int unsigned GAIN_W      = 24;
   localparam int unsigned SMOOTH_W    = 16;
   localparam int unsigned LEVEL_W     = 32;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   // shared multiplier: 25-bit signed by 32-bit signed
   localparam int unsigned MUL_A_W = GAIN_W + 1;
   localparam int unsigned MUL_P_W = MUL_A_W + LEVEL_W;
   // blend accumulator: two Q0.16-weighted 32-bit terms
   localparam int unsigned ACC_W   = LEVEL_W + SMOOTH_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_LENGTH   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_GAIN     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LEVEL = 4'd3;

   localparam logic [LEN_CFG_W-1:0] BURST_LENGTH_RESET = 7'd1;
   localparam logic [GAIN_W-1:0]    SCALE_GAIN_RESET   = 24'h01_0000;
   localparam logic [SMOOTH_W:0]    UNITY_Q16          = 17'h1_0000;

   typedef enum logic [1:0] {
      MUL_GAIN = 2'd0,
      MUL_NEW  = 2'd1,
      MUL_OLD  = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        take;
      logic        div_step;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        apply;
      logic        blend;
      logic        emit;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic kind;
      logic first_done;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [LEVEL_W-1:0] sat_level(
      input logic signed [LEVEL_W+1:0] v
   );
      logic signed [LEVEL_W-1:0] r;
      if (!v[LEVEL_W+1] && (v[LEVEL_W] || v[LEVEL_W-1])) begin
         r = {1'b0, {(LEVEL_W-1){1'b1}}};
      end else if (v[LEVEL_W+1] && !(v[LEVEL_W] && v[LEVEL_W-1])) begin
         r = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         r = v[LEVEL_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/aass_ifs.sv
// ---------------------------------------------------------------------------
// aass interfaces
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
interface aass_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [aass_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, cmd, sample, input ready);
   modport sink   (input valid, cmd, sample, output ready);
endinterface

interface aass_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [aass_pkg::LEVEL_W-1:0] level;
   logic                                from_calibration;

   modport source (output valid, level, from_calibration, input ready);
   modport sink   (input valid, level, from_calibration, output ready);
endinterface

interface aass_csr_if;
   logic                             valid;
   logic                             ready;
   logic [aass_pkg::CSR_INDEX_W-1:0] index;
   logic [aass_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/aass_dp.sv
// ---------------------------------------------------------------------------
// aass_dp
// Datapath: configuration registers, burst accumulator, radix-2 divider,
// shared multiplier, offset/smoothing arithmetic and the output register.
// ---------------------------------------------------------------------------
module aass_dp #(
   parameter int unsigned MAX_BURST = aass_pkg::MAX_BURST_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  aass_pkg::dp_cmd_type                cmd,
   output aass_pkg::dp_status_type             status,
   input  logic                                req_cmd,
   input  logic [aass_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                csr_valid,
   input  logic [aass_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aass_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [aass_pkg::LEVEL_W-1:0] rsp_level,
   output logic                                rsp_from_calibration
);
   import aass_pkg::*;

   localparam int unsigned LEN_W = $clog2(MAX_BURST + 1);
   localparam int unsigned SUM_W = SAMPLE_W + LEN_W;

   // configuration
   logic [LEN_CFG_W-1:0]      burst_length_ff, burst_length_in;
   logic [GAIN_W-1:0]         scale_gain_ff, scale_gain_in;
   logic [SMOOTH_W-1:0]       smoothing_ff, smoothing_in;
   logic signed [LEVEL_W-1:0] expected_level_ff, expected_level_in;

   // architectural state
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [LEN_W-1:0]          count_ff, count_in;
   logic                      kind_ff, kind_in;
   logic signed [LEVEL_W-1:0] offset_ff, offset_in;
   logic signed [LEVEL_W-1:0] smooth_ff, smooth_in;
   logic                      first_ff, first_in;

   // working registers
   logic [LEN_W-1:0]          rem_ff, rem_in;
   logic [SUM_W-1:0]          quo_ff, quo_in;
   logic signed [MUL_P_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [LEVEL_W-1:0] raw_ff, raw_in;
   logic signed [LEVEL_W-1:0] res_ff, res_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic signed [LEVEL_W-1:0] out_level_ff, out_level_in;
   logic                      out_cal_ff, out_cal_in;

   logic [LEN_W-1:0]          eff_len;
   logic [LEN_W-1:0]          count_inc;
   logic [SUM_W-1:0]          sum_new;
   logic [LEN_W:0]            trial;
   logic                      trial_ge;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [LEVEL_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [LEVEL_W-1:0]        scaled;
   logic signed [LEVEL_W+1:0] cal_sum;
   logic signed [LEVEL_W+1:0] meas_sum;
   logic signed [LEVEL_W-1:0] cal_level;
   logic signed [LEVEL_W-1:0] meas_level;
   logic signed [ACC_W-1:0]   blend_sum;
   logic                      out_free;

   // clamp the configured length into 1..MAX_BURST
   always_comb begin
      if (burst_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(burst_length_ff) > 32'(MAX_BURST)) begin
         eff_len = LEN_W'(MAX_BURST);
      end else begin
         eff_len = LEN_W'(burst_length_ff);
      end
   end

   assign count_inc = count_ff + LEN_W'(1);
   assign sum_new   = sum_ff + SUM_W'(req_sample);

   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge = trial >= {1'b0, eff_len};

   always_comb begin
      case (cmd.mul_sel)
         MUL_GAIN: begin
            mul_a = $signed({1'b0, scale_gain_ff});
            mul_b = $signed(LEVEL_W'(quo_ff));
         end
         MUL_NEW: begin
            mul_a = $signed(MUL_A_W'(UNITY_Q16 - {1'b0, smoothing_ff}));
            mul_b = raw_ff;
         end
         MUL_OLD: begin
            mul_a = $signed(MUL_A_W'(smoothing_ff));
            mul_b = smooth_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign scaled     = prod_ff[LEVEL_W+15:16];
   assign cal_sum    = {{2{expected_level_ff[LEVEL_W-1]}}, expected_level_ff}
                       - $signed({2'b00, scaled});
   assign meas_sum   = {{2{offset_ff[LEVEL_W-1]}}, offset_ff} + $signed({2'b00, scaled});
   assign cal_level  = sat_level(cal_sum);
   assign meas_level = sat_level(meas_sum);
   assign blend_sum  = acc_ff + prod_ff[ACC_W-1:0];

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      burst_length_in   = burst_length_ff;
      scale_gain_in     = scale_gain_ff;
      smoothing_in      = smoothing_ff;
      expected_level_in = expected_level_ff;
      sum_in            = sum_ff;
      count_in          = count_ff;
      kind_in           = kind_ff;
      offset_in         = offset_ff;
      smooth_in         = smooth_ff;
      first_in          = first_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      prod_in           = prod_ff;
      acc_in            = acc_ff;
      raw_in            = raw_ff;
      res_in            = res_ff;
      out_valid_in      = out_valid_ff;
      out_level_in      = out_level_ff;
      out_cal_in        = out_cal_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_BURST_LENGTH:   burst_length_in   = csr_data[LEN_CFG_W-1:0];
            CSR_SCALE_GAIN:     scale_gain_in     = csr_data[GAIN_W-1:0];
            CSR_SMOOTHING:      smoothing_in      = csr_data[SMOOTH_W-1:0];
            CSR_EXPECTED_LEVEL: expected_level_in = $signed(csr_data[LEVEL_W-1:0]);
            default: ;
         endcase
      end

      if (cmd.take) begin
         if (count_ff == '0) begin
            kind_in = req_cmd;
         end
         if (count_inc >= eff_len) begin
            // burst complete: hand the sum to the divider, restart gathering
            sum_in   = '0;
            count_in = '0;
            rem_in   = '0;
            quo_in   = sum_new;
         end else begin
            sum_in   = sum_new;
            count_in = count_inc;
         end
      end

      if (cmd.div_step) begin
         rem_in = trial_ge ? LEN_W'(trial - {1'b0, eff_len}) : trial[LEN_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], trial_ge};
      end

      if (cmd.mul_en) begin
         prod_in = mul_p;
      end
      if (cmd.acc_load) begin
         acc_in = prod_ff[ACC_W-1:0];
      end

      if (cmd.apply) begin
         if (kind_ff) begin
            offset_in = cal_level;
            res_in    = cal_level;
         end else begin
            raw_in = meas_level;
            if (!first_ff) begin
               smooth_in = meas_level;
               res_in    = meas_level;
               first_in  = 1'b1;
            end
         end
      end

      if (cmd.blend) begin
         smooth_in = blend_sum[LEVEL_W+15:16];
         res_in    = blend_sum[LEVEL_W+15:16];
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_level_in = res_ff;
         out_cal_in   = kind_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_length_ff   <= BURST_LENGTH_RESET;
         scale_gain_ff     <= SCALE_GAIN_RESET;
         smoothing_ff      <= '0;
         expected_level_ff <= '0;
         sum_ff            <= '0;
         count_ff          <= '0;
         kind_ff           <= 1'b0;
         offset_ff         <= '0;
         smooth_ff         <= '0;
         first_ff          <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         burst_length_ff   <= burst_length_in;
         scale_gain_ff     <= scale_gain_in;
         smoothing_ff      <= smoothing_in;
         expected_level_ff <= expected_level_in;
         sum_ff            <= sum_in;
         count_ff          <= count_in;
         kind_ff           <= kind_in;
         offset_ff         <= offset_in;
         smooth_ff         <= smooth_in;
         first_ff          <= first_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      raw_ff       <= raw_in;
      res_ff       <= res_in;
      out_level_ff <= out_level_in;
      out_cal_ff   <= out_cal_in;
   end

   assign status.last       = count_inc >= eff_len;
   assign status.kind       = kind_ff;
   assign status.first_done = first_ff;
   assign status.out_free   = out_free;

   assign rsp_valid            = out_valid_ff;
   assign rsp_level            = out_level_ff;
   assign rsp_from_calibration = out_cal_ff;

endmodule

// File: rtl/aass_ctrl.sv
// ---------------------------------------------------------------------------
// aass_ctrl
// Sequencer: takes samples, runs the divider for one quotient bit per
// cycle, then steps the shared multiplier through scale and smoothing.
// ---------------------------------------------------------------------------
module aass_ctrl #(
   parameter int unsigned MAX_BURST = aass_pkg::MAX_BURST_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  aass_pkg::dp_status_type status,
   output aass_pkg::dp_cmd_type    cmd
);
   import aass_pkg::*;

   localparam int unsigned LEN_W  = $clog2(MAX_BURST + 1);
   localparam int unsigned SUM_W  = SAMPLE_W + LEN_W;
   localparam int unsigned STEP_W = $clog2(SUM_W);

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_DIVIDE     = 8'b0000_0010,
      ST_SCALE      = 8'b0000_0100,
      ST_APPLY      = 8'b0000_1000,
      ST_WEIGHT_NEW = 8'b0001_0000,
      ST_WEIGHT_OLD = 8'b0010_0000,
      ST_BLEND      = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mul_sel  = MUL_GAIN;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.last) begin
                  step_in  = STEP_W'(SUM_W - 1);
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GAIN;
            state_in    = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            // calibration and the first measurement skip the smoothing step
            if (status.kind || !status.first_done) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_WEIGHT_NEW;
            end
         end
         ST_WEIGHT_NEW: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NEW;
            state_in    = ST_WEIGHT_OLD;
         end
         ST_WEIGHT_OLD: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_OLD;
            state_in     = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: rtl/adc_average_scale_smooth.sv
// ---------------------------------------------------------------------------
// adc_average_scale_smooth
// Burst averager with Q8.16 gain, stored offset and exponential smoothing.
// ---------------------------------------------------------------------------
// A sample that does not close a burst leaves the input ready; samples stream back to back.
// A closing sample holds the input until its result enters the output register: the
// restoring divider retires one quotient bit per cycle over the SUM_W-bit burst sum
// (SUM_W = 16 + clog2(MAX_BURST+1), 23 at 64), then one shared multiplier runs gain,
// new and old weight (the last two skipped for a calibrate burst or the first measure);
// the result waits while the output register is full. Sync reset restores defaults.
module adc_average_scale_smooth #(
   parameter int unsigned MAX_BURST = aass_pkg::MAX_BURST_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   aass_req_if.sink   req_if,
   aass_rsp_if.source rsp_if,
   aass_csr_if.sink   csr_if
);
   import aass_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // registers accept a transfer in every cycle
   assign csr_if.ready = 1'b1;

   aass_ctrl #(
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   aass_dp #(
      .MAX_BURST (MAX_BURST)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_cmd              (req_if.cmd),
      .req_sample           (req_if.sample),
      .csr_valid            (csr_if.valid),
      .csr_index            (csr_if.index),
      .csr_data             (csr_if.data),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_level            (rsp_if.level),
      .rsp_from_calibration (rsp_if.from_calibration)
   );

endmodule
